### hw/rtl/pcl_pkg.sv
// ----------------------------------------------------------------------------
// PCL page counter package
// Widths and character codes shared by the page counter and its interfaces.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pcl_pkg;

	localparam int BYTE_W         = 8;
	localparam int PAGE_W         = 32;
	localparam int COUNT_BITS_DEF = 32;

	localparam logic [7:0] CH_ESC      = 8'd27;
	localparam logic [7:0] CH_FF       = 8'd12;
	localparam logic [7:0] CH_RESET    = 8'h45;
	localparam logic [7:0] CH_PERCENT  = 8'h25;
	localparam logic [7:0] CH_DASH     = 8'h2d;
	localparam logic [7:0] CH_AMP      = 8'h26;
	localparam logic [7:0] CH_LPAR     = 8'h28;
	localparam logic [7:0] CH_RPAR     = 8'h29;
	localparam logic [7:0] CH_STAR     = 8'h2a;
	localparam logic [7:0] CH_LC_B     = 8'h62;
	localparam logic [7:0] CH_LC_C     = 8'h63;
	localparam logic [7:0] CH_LC_F     = 8'h66;
	localparam logic [7:0] CH_LC_I     = 8'h69;
	localparam logic [7:0] CH_LC_L     = 8'h6c;
	localparam logic [7:0] CH_LC_P     = 8'h70;
	localparam logic [7:0] CH_LC_S     = 8'h73;
	localparam logic [7:0] CH_UC_V     = 8'h56;
	localparam logic [7:0] CH_UC_W     = 8'h57;
	localparam logic [7:0] CH_UC_X     = 8'h58;
	localparam logic [7:0] CH_DIGIT_LO = 8'h30;
	localparam logic [7:0] CH_DIGIT_HI = 8'h39;
	localparam logic [7:0] CH_GROUP_LO = 8'd33;
	localparam logic [7:0] CH_GROUP_HI = 8'd47;
	localparam logic [7:0] CH_PARAM_LO = 8'd96;
	localparam logic [7:0] CH_PARAM_HI = 8'd126;
	localparam logic [7:0] CH_TERM_LO  = 8'd64;
	localparam logic [7:0] CH_TERM_HI  = 8'd94;

endpackage

### hw/rtl/pcl_byte_if.sv
// ----------------------------------------------------------------------------
// PCL byte channel
// Carries one print stream byte per item with a valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pcl_byte_if;

	logic                       valid;
	logic                       ready;
	logic [pcl_pkg::BYTE_W-1:0] byte_in;

	modport source (output valid, output byte_in, input ready);
	modport sink (input valid, input byte_in, output ready);

endinterface

### hw/rtl/pcl_result_if.sv
// ----------------------------------------------------------------------------
// PCL result channel
// Carries the page count and per-byte flags with a valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pcl_result_if;

	logic                       valid;
	logic                       ready;
	logic [pcl_pkg::PAGE_W-1:0] page_count;
	logic                       page_seen;
	logic                       skipping;

	modport source (output valid, output page_count, output page_seen, output skipping,
		input ready);
	modport sink (input valid, input page_count, input page_seen, input skipping,
		output ready);

endinterface

### hw/rtl/pcl_page_counter.sv
// ----------------------------------------------------------------------------
// PCL page counter
// Parses a PCL5 byte stream, skips binary payloads and counts form feeds.
// ----------------------------------------------------------------------------
// Channel    Dir  Payload                          Handshake
// byte_ch    in   byte_in[7:0]                     valid/ready
// result_ch  out  page_count[31:0], page_seen,     valid/ready
//                 skipping
//
// Each byte is registered, parsed combinationally and its result registered,
// so one item per cycle is sustained while result_ch does not stall.
// A held byte advances the parser when the result register is free or drained.
// A stall on result_ch holds both registers; byte_ch ready drops only when
// the input register is full and cannot move.
// Reset clears the parser state and page count to normal text and zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcl_page_counter #(
	parameter int COUNT_BITS = pcl_pkg::COUNT_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	pcl_byte_if.sink      byte_ch,
	pcl_result_if.source  result_ch
);

	typedef enum logic [2:0] {
		M_NORMAL   = 3'd0,
		M_COMMAND  = 3'd1,
		M_EXITCHK  = 3'd2,
		M_GROUPPAR = 3'd3,
		M_VALUE    = 3'd4,
		M_SKIP     = 3'd5
	} mode_t;

	localparam logic [2:0] EXP_NONE  = 3'd0;
	localparam logic [2:0] EXP_AMP   = 3'd1;
	localparam logic [2:0] EXP_LPAR  = 3'd2;
	localparam logic [2:0] EXP_RPAR  = 3'd3;
	localparam logic [2:0] EXP_STAR  = 3'd4;
	localparam logic [2:0] EXP_X     = 3'd5;
	localparam logic [2:0] EXP_W     = 3'd6;
	localparam logic [2:0] EXP_WV    = 3'd7;
	localparam logic [2:0] EXIT_DONE = 3'd6;

	localparam int CW = COUNT_BITS;
	localparam int PW = COUNT_BITS + 4;
	localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};

	logic                        valid_s1;
	logic [pcl_pkg::BYTE_W-1:0]  byte_s1;
	logic                        out_valid_q;
	logic [pcl_pkg::PAGE_W-1:0]  page_count_q;
	logic                        page_seen_q;
	logic                        skipping_q;

	mode_t                       mode_q;
	logic [2:0]                  expect_q;
	logic [CW-1:0]               skip_q;
	logic [pcl_pkg::PAGE_W-1:0]  pages_q;

	mode_t                       mode_d;
	logic [2:0]                  expect_d;
	logic [CW-1:0]               skip_d;
	logic [pcl_pkg::PAGE_W-1:0]  pages_d;
	logic                        seen_d;
	logic                        skipped_d;

	logic                        s1_adv;
	logic                        is_digit;
	logic [CW-1:0]               digit;
	logic [PW-1:0]               times_ten;
	logic                        term_hit;
	logic [7:0]                  c;

	assign s1_adv          = !out_valid_q || result_ch.ready;
	assign byte_ch.ready   = !valid_s1 || s1_adv;

	assign result_ch.valid      = out_valid_q;
	assign result_ch.page_count = page_count_q;
	assign result_ch.page_seen  = page_seen_q;
	assign result_ch.skipping   = skipping_q;

	assign c        = byte_s1;
	assign is_digit = (c >= pcl_pkg::CH_DIGIT_LO) && (c <= pcl_pkg::CH_DIGIT_HI);
	assign digit    = CW'(c[3:0]);

	assign times_ten = ({4'b0000, skip_q} << 3) + ({4'b0000, skip_q} << 1)
		+ {4'b0000, digit};

	always_comb begin
		term_hit = 1'b0;
		if (skip_q != '0) begin
			case (expect_q)
				EXP_X:   term_hit = (c == pcl_pkg::CH_UC_X);
				EXP_W:   term_hit = (c == pcl_pkg::CH_UC_W);
				EXP_WV:  term_hit = (c == pcl_pkg::CH_UC_W) || (c == pcl_pkg::CH_UC_V);
				default: term_hit = 1'b0;
			endcase
		end
	end

	always_comb begin
		mode_d    = mode_q;
		expect_d  = expect_q;
		skip_d    = skip_q;
		pages_d   = pages_q;
		seen_d    = 1'b0;
		skipped_d = 1'b0;
		case (mode_q)
			M_NORMAL: begin
				if (c == pcl_pkg::CH_ESC) begin
					mode_d = M_COMMAND;
				end else if (c == pcl_pkg::CH_FF) begin
					pages_d = pages_q + 1'b1;
					seen_d  = 1'b1;
				end
			end
			M_COMMAND: begin
				if (c == pcl_pkg::CH_RESET) begin
					mode_d = M_NORMAL;
				end else if (c == pcl_pkg::CH_PERCENT) begin
					mode_d = M_EXITCHK;
				end else if (c >= pcl_pkg::CH_GROUP_LO && c <= pcl_pkg::CH_GROUP_HI) begin
					if (c == pcl_pkg::CH_AMP) begin
						expect_d = EXP_AMP;
					end else if (c == pcl_pkg::CH_LPAR) begin
						expect_d = EXP_LPAR;
					end else if (c == pcl_pkg::CH_RPAR) begin
						expect_d = EXP_RPAR;
					end else if (c == pcl_pkg::CH_STAR) begin
						expect_d = EXP_STAR;
					end
					mode_d = M_GROUPPAR;
					skip_d = '0;
				end else begin
					mode_d = M_NORMAL;
				end
			end
			M_EXITCHK: begin
				if (expect_q == EXP_NONE) begin
					if (c == pcl_pkg::CH_DASH) begin
						expect_d = 3'd1;
					end else begin
						mode_d = M_NORMAL;
					end
				end else if (expect_q != EXIT_DONE) begin
					if (c != {5'b00110, expect_q}) begin
						expect_d = EXP_NONE;
						mode_d   = M_NORMAL;
					end else begin
						expect_d = expect_q + 3'd1;
					end
				end else begin
					expect_d = EXP_NONE;
					mode_d   = M_NORMAL;
				end
			end
			M_GROUPPAR: begin
				case (expect_q)
					EXP_AMP: begin
						if (c == pcl_pkg::CH_LC_B) begin
							expect_d = EXP_W;
						end else if (c == pcl_pkg::CH_LC_P) begin
							expect_d = EXP_X;
						end else begin
							expect_d = EXP_NONE;
						end
					end
					EXP_LPAR: begin
						expect_d = (c == pcl_pkg::CH_LC_F || c == pcl_pkg::CH_LC_S) ?
							EXP_W : EXP_NONE;
					end
					EXP_RPAR: begin
						expect_d = (c == pcl_pkg::CH_LC_S) ? EXP_W : EXP_NONE;
					end
					EXP_STAR: begin
						if (c == pcl_pkg::CH_LC_B) begin
							expect_d = EXP_WV;
						end else if (c == pcl_pkg::CH_LC_C || c == pcl_pkg::CH_LC_I ||
								c == pcl_pkg::CH_LC_L) begin
							expect_d = EXP_W;
						end else begin
							expect_d = EXP_NONE;
						end
					end
					default: begin
						expect_d = expect_q;
					end
				endcase
				mode_d = M_VALUE;
			end
			M_VALUE: begin
				if (is_digit) begin
					if (expect_q == EXP_NONE) begin
						skip_d = digit;
					end else if (times_ten[PW-1 -: 4] != 4'd0) begin
						skip_d = CNT_MAX;
					end else begin
						skip_d = times_ten[CW-1:0];
					end
				end else if (c >= pcl_pkg::CH_PARAM_LO && c <= pcl_pkg::CH_PARAM_HI) begin
					skip_d = '0;
				end else if (c >= pcl_pkg::CH_TERM_LO && c <= pcl_pkg::CH_TERM_HI) begin
					mode_d   = term_hit ? M_SKIP : M_NORMAL;
					expect_d = EXP_NONE;
				end
			end
			M_SKIP: begin
				skipped_d = 1'b1;
				if (skip_q != CW'(1)) begin
					skip_d = skip_q - 1'b1;
				end else begin
					mode_d = M_NORMAL;
				end
			end
			default: begin
				mode_d = M_NORMAL;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ch.ready) begin
			valid_s1 <= byte_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ch.valid && byte_ch.ready) begin
			byte_s1 <= byte_ch.byte_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			mode_q      <= M_NORMAL;
			expect_q    <= EXP_NONE;
			skip_q      <= '0;
			pages_q     <= '0;
		end else begin
			if (s1_adv) begin
				out_valid_q <= valid_s1;
			end
			if (s1_adv && valid_s1) begin
				mode_q   <= mode_d;
				expect_q <= expect_d;
				skip_q   <= skip_d;
				pages_q  <= pages_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && valid_s1) begin
			page_count_q <= pages_d;
			page_seen_q  <= seen_d;
			skipping_q   <= skipped_d;
		end
	end

`ifndef SYNTHESIS
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(page_seen_q && skipping_q))
		else $error("page_seen and skipping both set on one result");

	a_count_tracks_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (page_count_q == pages_q))
		else $error("result page count differs from the page counter");

	a_skip_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == M_SKIP) |-> (skip_q != '0))
		else $error("skip mode with a zero skip count");

	a_normal_no_expect: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == M_NORMAL) |-> (expect_q == EXP_NONE))
		else $error("expected terminator left set in normal text");

	a_page_step: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && valid_s1 && mode_q == M_NORMAL && byte_s1 == pcl_pkg::CH_FF)
		|=> (pages_q == $past(pages_q) + 1'b1))
		else $error("form feed in normal text did not advance the page count");
`endif

endmodule
